[rtl/core/chunk_map_span_lookup_macros.svh]
// Assertion macros for the chunk map span lookup block.
// Included by the controller and the datapath; no other dependencies.
`ifndef CHUNK_MAP_SPAN_LOOKUP_MACROS_SVH
`define CHUNK_MAP_SPAN_LOOKUP_MACROS_SVH

// Same-cycle implication
`define CMSL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define CMSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Invariant
`define CMSL_ASSERT_HOLD(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

`endif

[rtl/core/cmsl_pkg.sv]
// Shared types and constants for the chunk map span lookup block.
// No dependencies; used by every module of the block.
`default_nettype none

package cmsl_pkg;

	// Payload field widths
	localparam int FIELD_W   = 48;
	localparam int CHUNK_W   = 12;
	localparam int HDR_BYTES = 16;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd2;

	// Compression mode that enables the size check
	localparam logic [1:0] MODE_UNCOMP = 2'd2;
	localparam logic [1:0] MODE_RESET  = 2'd2;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_SEEK  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		STAT_OK        = 4'd0,
		STAT_TRUNCATED = 4'd1,
		STAT_EMPTY     = 4'd2,
		STAT_PAST_END  = 4'd3,
		STAT_OVERFLOW  = 4'd4,
		STAT_FULL      = 4'd5,
		STAT_RANGE     = 4'd6,
		STAT_MISMATCH  = 4'd7,
		STAT_NONE      = 4'd8
	} status_t;

	typedef struct packed {
		op_t                op;
		logic [FIELD_W-1:0] packed_size;
		logic [FIELD_W-1:0] plain_size;
		logic [FIELD_W-1:0] target_position;
		logic [FIELD_W-1:0] want_bytes;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [CHUNK_W-1:0] span_chunk;
		logic [FIELD_W-1:0] span_packed_offset;
		logic [FIELD_W-1:0] span_packed_size;
		logic [FIELD_W-1:0] span_inner_offset;
		logic [FIELD_W-1:0] span_bytes;
		logic               span_reload;
		logic [FIELD_W-1:0] position_now;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_ADD_COMMIT,
		S_SEARCH,
		S_FETCH,
		S_LIMIT,
		S_FINISH
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic dispatch;
		logic add_commit;
		logic search_step;
		logic fetch;
		logic limit;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic read_stop;
		logic search_done;
		logic mismatch;
	} sts_t;

endpackage

`default_nettype wire

[rtl/core/cmsl_dp.sv]
// Datapath: configuration, table state, chunk table memory, search window
// and result register. Depends on cmsl_pkg and the assertion macro header.
`default_nettype none
`include "chunk_map_span_lookup_macros.svh"

module cmsl_dp #(
	parameter int MAX_CHUNKS = 4096,
	parameter int POS_BITS   = 48
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [cmsl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [cmsl_pkg::FIELD_W-1:0]        cfg_data,
	input  cmsl_pkg::item_t                     item,
	input  cmsl_pkg::cmd_t                      cmd,
	output cmsl_pkg::sts_t                      sts,
	output cmsl_pkg::result_t                   result
);

	localparam int P      = POS_BITS;
	localparam int P1     = POS_BITS + 1;
	localparam int ROOM_W = POS_BITS + 2;
	localparam int ENT_W  = 4 * POS_BITS;
	localparam int IDX_W  = $clog2(MAX_CHUNKS);
	localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
	localparam int FW     = cmsl_pkg::FIELD_W;
	localparam int CW     = cmsl_pkg::CHUNK_W;

	// Configuration
	logic [P-1:0] file_size_q;
	logic [P-1:0] first_off_q;
	logic [1:0]   mode_q;

	// Captured item
	cmsl_pkg::op_t op_q;
	logic [P-1:0]  psz_q;
	logic [P-1:0]  usz_q;
	logic [P-1:0]  target_q;
	logic [P-1:0]  want_q;

	// Table state
	logic [P-1:0]     nha_q;
	logic [P-1:0]     plain_total_q;
	logic [P-1:0]     rd_pos_q;
	logic [CNT_W-1:0] chunk_total_q;
	logic [IDX_W-1:0] loaded_chunk_q;
	logic             loaded_valid_q;

	// Working registers
	logic [ROOM_W-1:0] room_q;
	logic [CNT_W-1:0]  lo_q;
	logic [CNT_W-1:0]  hi_q;
	logic [IDX_W-1:0]  mid_q;
	logic [IDX_W-1:0]  sel_idx_q;
	logic [P-1:0]      off_q;
	logic [P-1:0]      avail_q;
	logic              need_q;
	cmsl_pkg::result_t res_q;

	// Chunk table: {packed offset, packed size, plain offset, plain size}
	logic [ENT_W-1:0] mem [MAX_CHUNKS];
	logic [ENT_W-1:0] rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             rd_en;
	logic             mem_we;
	logic [ENT_W-1:0] wr_data;

	logic [P-1:0] ent_usz, ent_uoff, ent_psz, ent_poff;

	logic [P:0]   span_left;
	logic         tbl_empty, range_err, want_zero, read_stop, is_read;
	logic         seek_err;
	logic         le, search_done, need, mismatch;
	logic [CNT_W-1:0] lo_n, hi_n, mid_n, idx_n;
	cmsl_pkg::status_t add_status;
	logic         add_ok;
	logic [P-1:0] grant;
	cmsl_pkg::result_t res_d;
	logic         res_we;

	assign ent_usz  = rd_q[P-1:0];
	assign ent_uoff = rd_q[2*P-1:P];
	assign ent_psz  = rd_q[3*P-1:2*P];
	assign ent_poff = rd_q[4*P-1:3*P];

	// Read op early checks
	assign span_left = {1'b0, plain_total_q} - {1'b0, rd_pos_q};
	assign tbl_empty = (chunk_total_q == '0);
	assign range_err = span_left[P] || (want_q > span_left[P-1:0]);
	assign want_zero = (want_q == '0);
	assign read_stop = tbl_empty || range_err || want_zero;
	assign is_read   = (op_q == cmsl_pkg::OP_READ);

	assign seek_err = (target_q > plain_total_q);

	// One binary search probe: narrow the window around the read position
	assign le          = (ent_uoff <= rd_pos_q);
	assign lo_n        = le ? (CNT_W'(mid_q) + CNT_W'(1)) : lo_q;
	assign hi_n        = le ? hi_q : CNT_W'(mid_q);
	assign search_done = !(lo_n < hi_n);
	assign mid_n       = lo_n + ((hi_n - lo_n) >> 1);
	assign idx_n       = (lo_n == '0) ? '0 : (lo_n - CNT_W'(1));

	// Chunk load checks
	assign need     = !loaded_valid_q || (loaded_chunk_q != sel_idx_q);
	assign mismatch = need && (mode_q == cmsl_pkg::MODE_UNCOMP) && (ent_psz != ent_usz)
		&& ({1'b0, ent_psz} != ({1'b0, ent_usz} + P1'(cmsl_pkg::HDR_BYTES)));

	assign grant = (want_q < avail_q) ? want_q : avail_q;

	// Add op checks, in priority order
	always_comb begin
		if (room_q[ROOM_W-1]) begin
			add_status = cmsl_pkg::STAT_TRUNCATED;
		end else if (psz_q == '0 || usz_q == '0) begin
			add_status = cmsl_pkg::STAT_EMPTY;
		end else if (psz_q > room_q[P-1:0]) begin
			add_status = cmsl_pkg::STAT_PAST_END;
		end else if (usz_q > ~plain_total_q) begin
			add_status = cmsl_pkg::STAT_OVERFLOW;
		end else if (chunk_total_q >= CNT_W'(MAX_CHUNKS)) begin
			add_status = cmsl_pkg::STAT_FULL;
		end else begin
			add_status = cmsl_pkg::STAT_OK;
		end
	end
	assign add_ok = (add_status == cmsl_pkg::STAT_OK);

	// Memory port control
	assign mem_we  = cmd.add_commit && add_ok;
	assign wr_data = {nha_q + P'(cmsl_pkg::HDR_BYTES), psz_q, plain_total_q, usz_q};
	assign rd_en   = (cmd.dispatch && is_read && !read_stop) || cmd.search_step;

	always_comb begin
		if (cmd.dispatch) begin
			rd_addr = chunk_total_q[CNT_W-1:1];
		end else if (search_done) begin
			rd_addr = idx_n[IDX_W-1:0];
		end else begin
			rd_addr = mid_n[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[chunk_total_q[IDX_W-1:0]] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Configuration and table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q    <= '0;
			first_off_q    <= '0;
			mode_q         <= cmsl_pkg::MODE_RESET;
			nha_q          <= '0;
			plain_total_q  <= '0;
			rd_pos_q       <= '0;
			chunk_total_q  <= '0;
			loaded_chunk_q <= '0;
			loaded_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cmsl_pkg::CFG_FILE_SIZE:    file_size_q <= P'(cfg_data);
					cmsl_pkg::CFG_FIRST_OFFSET: first_off_q <= P'(cfg_data);
					cmsl_pkg::CFG_MODE:         mode_q      <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (cmd.dispatch) begin
				unique case (op_q)
					cmsl_pkg::OP_CLEAR: begin
						nha_q          <= first_off_q;
						plain_total_q  <= '0;
						rd_pos_q       <= '0;
						chunk_total_q  <= '0;
						loaded_chunk_q <= '0;
						loaded_valid_q <= 1'b0;
					end
					cmsl_pkg::OP_SEEK: begin
						if (!seek_err) begin
							rd_pos_q <= target_q;
						end
					end
					default: ;
				endcase
			end
			if (mem_we) begin
				chunk_total_q <= chunk_total_q + CNT_W'(1);
				nha_q         <= nha_q + P'(cmsl_pkg::HDR_BYTES) + psz_q;
				plain_total_q <= plain_total_q + usz_q;
			end
			if (cmd.finish) begin
				rd_pos_q <= rd_pos_q + grant;
				if (need_q) begin
					loaded_chunk_q <= sel_idx_q;
					loaded_valid_q <= 1'b1;
				end
			end
		end
	end

	// Item capture and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= item.op;
			psz_q    <= P'(item.packed_size);
			usz_q    <= P'(item.plain_size);
			target_q <= P'(item.target_position);
			want_q   <= P'(item.want_bytes);
		end
		if (cmd.dispatch) begin
			room_q <= {2'b00, file_size_q} - {2'b00, nha_q} - ROOM_W'(cmsl_pkg::HDR_BYTES);
			lo_q   <= '0;
			hi_q   <= chunk_total_q;
			mid_q  <= chunk_total_q[CNT_W-1:1];
		end
		if (cmd.search_step) begin
			lo_q      <= lo_n;
			hi_q      <= hi_n;
			mid_q     <= mid_n[IDX_W-1:0];
			sel_idx_q <= idx_n[IDX_W-1:0];
		end
		if (cmd.fetch) begin
			off_q  <= rd_pos_q - ent_uoff;
			need_q <= need;
		end
		if (cmd.limit) begin
			avail_q <= (ent_usz > off_q) ? (ent_usz - off_q) : '0;
		end
		if (res_we) begin
			res_q <= res_d;
		end
	end

	// Result assembly
	always_comb begin
		res_d              = '0;
		res_we             = 1'b0;
		res_d.position_now = FW'(rd_pos_q);
		if (cmd.dispatch) begin
			res_we = 1'b1;
			unique case (op_q)
				cmsl_pkg::OP_CLEAR: res_d.position_now = '0;
				cmsl_pkg::OP_ADD:   res_we = 1'b0;
				cmsl_pkg::OP_SEEK: begin
					if (seek_err) begin
						res_d.status = cmsl_pkg::STAT_RANGE;
					end else begin
						res_d.position_now = FW'(target_q);
					end
				end
				cmsl_pkg::OP_READ: begin
					if (tbl_empty) begin
						res_d.status = cmsl_pkg::STAT_NONE;
					end else if (range_err) begin
						res_d.status = cmsl_pkg::STAT_RANGE;
					end else if (!want_zero) begin
						res_we = 1'b0;
					end
				end
				default: ;
			endcase
		end
		if (cmd.add_commit) begin
			res_we       = 1'b1;
			res_d.status = add_status;
			if (add_ok) begin
				res_d.span_chunk = CW'(chunk_total_q);
			end
		end
		if (cmd.fetch && mismatch) begin
			res_we                   = 1'b1;
			res_d.status             = cmsl_pkg::STAT_MISMATCH;
			res_d.span_chunk         = CW'(sel_idx_q);
			res_d.span_packed_offset = FW'(ent_poff);
			res_d.span_packed_size   = FW'(ent_psz);
		end
		if (cmd.finish) begin
			res_we                   = 1'b1;
			res_d.span_chunk         = CW'(sel_idx_q);
			res_d.span_packed_offset = FW'(ent_poff);
			res_d.span_packed_size   = FW'(ent_psz);
			res_d.span_inner_offset  = FW'(off_q);
			res_d.span_bytes         = FW'(grant);
			res_d.span_reload        = need_q;
			res_d.position_now       = FW'(rd_pos_q + grant);
		end
	end

	assign result          = res_q;
	assign sts.op          = op_q;
	assign sts.read_stop   = read_stop;
	assign sts.search_done = search_done;
	assign sts.mismatch    = mismatch;

	`CMSL_ASSERT_IMPLY(a_search_window, clk, arst_n, cmd.search_step, lo_q < hi_q, "search window empty")
	`CMSL_ASSERT_HOLD(a_total_bound, clk, arst_n, chunk_total_q <= CNT_W'(MAX_CHUNKS), "table overfilled")
	`CMSL_ASSERT_IMPLY(a_loaded_held, clk, arst_n, loaded_valid_q, CNT_W'(loaded_chunk_q) < chunk_total_q, "loaded chunk outside table")

endmodule

`default_nettype wire

[rtl/core/cmsl_ctrl.sv]
// Controller state machine: sequences each item through the datapath.
// Depends on cmsl_pkg and the assertion macro header.
`default_nettype none
`include "chunk_map_span_lookup_macros.svh"

module cmsl_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             start,
	input  cmsl_pkg::sts_t  sts,
	output logic            busy,
	output logic            done,
	output cmsl_pkg::cmd_t  cmd
);

	cmsl_pkg::state_t state_q, state_d;
	logic             done_q, done_d;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cmsl_pkg::S_IDLE: begin
				if (start) begin
					state_d = cmsl_pkg::S_DISPATCH;
				end
			end
			cmsl_pkg::S_DISPATCH: begin
				unique case (sts.op) inside
					cmsl_pkg::OP_CLEAR, cmsl_pkg::OP_SEEK: state_d = cmsl_pkg::S_IDLE;
					cmsl_pkg::OP_ADD: state_d = cmsl_pkg::S_ADD_COMMIT;
					cmsl_pkg::OP_READ: begin
						state_d = sts.read_stop ? cmsl_pkg::S_IDLE : cmsl_pkg::S_SEARCH;
					end
					default: state_d = cmsl_pkg::S_IDLE;
				endcase
			end
			cmsl_pkg::S_ADD_COMMIT: state_d = cmsl_pkg::S_IDLE;
			cmsl_pkg::S_SEARCH: begin
				if (sts.search_done) begin
					state_d = cmsl_pkg::S_FETCH;
				end
			end
			cmsl_pkg::S_FETCH: begin
				state_d = sts.mismatch ? cmsl_pkg::S_IDLE : cmsl_pkg::S_LIMIT;
			end
			cmsl_pkg::S_LIMIT:  state_d = cmsl_pkg::S_FINISH;
			cmsl_pkg::S_FINISH: state_d = cmsl_pkg::S_IDLE;
			default:            state_d = cmsl_pkg::S_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd             = '0;
		cmd.capture     = (state_q == cmsl_pkg::S_IDLE) && start;
		cmd.dispatch    = (state_q == cmsl_pkg::S_DISPATCH);
		cmd.add_commit  = (state_q == cmsl_pkg::S_ADD_COMMIT);
		cmd.search_step = (state_q == cmsl_pkg::S_SEARCH);
		cmd.fetch       = (state_q == cmsl_pkg::S_FETCH);
		cmd.limit       = (state_q == cmsl_pkg::S_LIMIT);
		cmd.finish      = (state_q == cmsl_pkg::S_FINISH);
		// result is registered as the item wraps up
		done_d          = (state_q != cmsl_pkg::S_IDLE) && (state_d == cmsl_pkg::S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmsl_pkg::S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	assign busy = (state_q != cmsl_pkg::S_IDLE);
	assign done = done_q;

	`CMSL_ASSERT_IMPLY(a_done_after_work, clk, arst_n, done, $past(busy), "strobe without work")
	`CMSL_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, start && !busy, state_q == cmsl_pkg::S_DISPATCH, "accepted item not dispatched")
	`CMSL_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "strobe longer than one cycle")

endmodule

`default_nettype wire

[rtl/core/chunk_map_span_lookup.sv]
// Top level of the chunk map span lookup block: controller plus datapath.
// Depends on cmsl_pkg, cmsl_ctrl and cmsl_dp.
//
// An item is taken when start is high and busy is low; its single result is
// presented on result for one cycle with done high, and the receiver cannot
// stall it. busy drops in the strobe cycle, so the next item can be taken at
// the edge that ends it. Clear and seek finish in the dispatch state, add goes
// on through the commit state, and a read that stops early (empty table, out
// of range, zero bytes) ends in the dispatch state. A full read runs through
// dispatch, P binary search probes, fetch, limit and finish, where P is at most
// floor(log2(chunk count)) + 1, and it ends after fetch when the size check
// fails. The chunk table has one read port and is probed once per cycle. The
// table needs no clearing pass after reset. Config registers are always ready
// and must be written only while busy is low.
`default_nettype none

module chunk_map_span_lookup #(
	parameter int MAX_CHUNKS = 4096,
	parameter int POS_BITS   = 48
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  cmsl_pkg::item_t                  item,
	output logic                             busy,
	output logic                             done,
	output cmsl_pkg::result_t                result,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [cmsl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [cmsl_pkg::FIELD_W-1:0]     cfg_data
);

	cmsl_pkg::cmd_t cmd;
	cmsl_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	cmsl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	cmsl_dp #(
		.MAX_CHUNKS (MAX_CHUNKS),
		.POS_BITS   (POS_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.result    (result)
	);

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking bench for chunk_map_span_lookup: directed table, random sessions, long table.
// Depends on cmsl_pkg and the chunk_map_span_lookup RTL; results are checked in order against
// an in-bench copy of the chunk table, search and read-position logic.
`timescale 1ns / 1ps

module tb_top;
	import cmsl_pkg::*;

	localparam int MAX_CHUNKS = 4096;
	localparam longint unsigned POS_MASK = 64'h0000_FFFF_FFFF_FFFF;
	localparam int QUIET_LIMIT = 3000;
	localparam int TAIL_CYCLES = 40;
	localparam int ITEMS_SLOW_GAPS = 330;
	localparam int ITEMS_FEW_GAPS = 330;
	localparam int ITEMS_NO_GAPS = 330;
	localparam int LONG_CHUNKS = 256;
	localparam int LONG_MIXED = 60;
	localparam int SHOW_MAX = 10;

	typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

	// one line of the directed table: either a register write or an item
	typedef struct {
		row_kind_t kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [FIELD_W-1:0] reg_val;
		item_t cmd;
		bit typed;
		result_t known;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	item_t item = '0;
	logic busy;
	logic done;
	result_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FIELD_W-1:0] cfg_data = '0;

	int idle_pct = 0;
	int mismatches = 0;
	result_t owed_spans[$];
	stim_row_t rows[$];

	// bench copy of the registers
	longint unsigned r_file_size = 0;
	longint unsigned r_first_off = 0;
	logic [1:0] r_mode = MODE_RESET;

	// bench copy of the chunk table and read state
	longint unsigned t_next_hdr = 0;
	longint unsigned t_pk_off [MAX_CHUNKS];
	longint unsigned t_pk_size [MAX_CHUNKS];
	longint unsigned t_pl_off [MAX_CHUNKS];
	longint unsigned t_pl_size [MAX_CHUNKS];
	int t_count = 0;
	longint unsigned t_plain_end = 0;
	longint unsigned t_pos = 0;
	int t_loaded = 0;
	bit t_loaded_ok = 1'b0;

	chunk_map_span_lookup i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// append a span to the tail of the owed list
	function automatic void owe_span(input result_t r);
		owed_spans.insert(owed_spans.size(), r);
	endfunction

	// append a line to the directed table
	function automatic void add_row(input stim_row_t row);
		rows.insert(rows.size(), row);
	endfunction

	// Apply one item to the bench table and return the span it yields
	function automatic result_t step_chunk_map(input item_t it);
		result_t r;
		longint unsigned psz, usz, tgt, want, off, avail, grant;
		int lo, hi, mid, idx;
		bit need;
		r = '0;
		psz = it.packed_size;
		usz = it.plain_size;
		tgt = it.target_position;
		want = it.want_bytes;
		case (it.op)
			OP_CLEAR: begin
				t_next_hdr = r_first_off;
				t_count = 0;
				t_plain_end = 0;
				t_pos = 0;
				t_loaded = 0;
				t_loaded_ok = 1'b0;
			end
			OP_ADD: begin
				if (t_next_hdr >= r_file_size || r_file_size - t_next_hdr < HDR_BYTES)
					r.status = STAT_TRUNCATED;
				else if (psz == 0 || usz == 0)
					r.status = STAT_EMPTY;
				else if (psz > r_file_size - t_next_hdr - HDR_BYTES)
					r.status = STAT_PAST_END;
				else if (usz > POS_MASK - t_plain_end)
					r.status = STAT_OVERFLOW;
				else if (t_count >= MAX_CHUNKS)
					r.status = STAT_FULL;
				else begin
					t_pk_off[t_count] = t_next_hdr + HDR_BYTES;
					t_pk_size[t_count] = psz;
					t_pl_off[t_count] = t_plain_end;
					t_pl_size[t_count] = usz;
					r.span_chunk = CHUNK_W'(t_count);
					t_count++;
					t_next_hdr = t_next_hdr + HDR_BYTES + psz;
					t_plain_end += usz;
				end
			end
			OP_SEEK: begin
				if (tgt > t_plain_end)
					r.status = STAT_RANGE;
				else
					t_pos = tgt;
			end
			default: begin
				if (t_count == 0)
					r.status = STAT_NONE;
				else if (t_pos > t_plain_end || want > t_plain_end - t_pos)
					r.status = STAT_RANGE;
				else if (want != 0) begin
					// last chunk whose first position is not past the read position
					lo = 0;
					hi = t_count;
					while (lo < hi) begin
						mid = lo + (hi - lo) / 2;
						if (t_pl_off[mid] <= t_pos)
							lo = mid + 1;
						else
							hi = mid;
					end
					idx = (lo == 0) ? 0 : lo - 1;
					need = !t_loaded_ok || t_loaded != idx;
					r.span_chunk = CHUNK_W'(idx);
					r.span_packed_offset = FIELD_W'(t_pk_off[idx]);
					r.span_packed_size = FIELD_W'(t_pk_size[idx]);
					// stored chunks must be raw or raw plus a header
					if (need && r_mode == MODE_UNCOMP && t_pk_size[idx] != t_pl_size[idx] &&
							t_pk_size[idx] != t_pl_size[idx] + HDR_BYTES) begin
						r.status = STAT_MISMATCH;
					end else begin
						off = t_pos - t_pl_off[idx];
						avail = (t_pl_size[idx] > off) ? t_pl_size[idx] - off : 0;
						grant = (want < avail) ? want : avail;
						if (need) begin
							t_loaded = idx;
							t_loaded_ok = 1'b1;
							r.span_reload = 1'b1;
						end
						r.span_inner_offset = FIELD_W'(off);
						r.span_bytes = FIELD_W'(grant);
						t_pos += grant;
					end
				end
			end
		endcase
		r.position_now = FIELD_W'(t_pos);
		return r;
	endfunction

	function automatic longint unsigned rnd48();
		return {$urandom, $urandom} & POS_MASK;
	endfunction

	function automatic longint unsigned rnd_upto(input longint unsigned hi);
		if (hi >= POS_MASK)
			return rnd48();
		return rnd48() % (hi + 1);
	endfunction

	// field value biased toward the corners
	function automatic longint unsigned edge48();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return POS_MASK;
			3: return $urandom_range(0, 255);
			default: return rnd48();
		endcase
	endfunction

	function automatic item_t mk_item(input op_t op, input longint unsigned ps, us, tg, wb);
		item_t it;
		it.op = op;
		it.packed_size = FIELD_W'(ps);
		it.plain_size = FIELD_W'(us);
		it.target_position = FIELD_W'(tg);
		it.want_bytes = FIELD_W'(wb);
		return it;
	endfunction

	function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input longint unsigned val);
		stim_row_t row;
		row.kind = ROW_REG;
		row.reg_idx = idx;
		row.reg_val = FIELD_W'(val);
		row.cmd = '0;
		row.typed = 1'b0;
		row.known = '0;
		return row;
	endfunction

	function automatic stim_row_t item_row(input op_t op, input longint unsigned ps, us, tg, wb);
		stim_row_t row;
		row = reg_row(CFG_FILE_SIZE, 0);
		row.kind = ROW_ITEM;
		row.cmd = mk_item(op, ps, us, tg, wb);
		return row;
	endfunction

	// item whose whole result is obvious: a status, all spans zero, and the position
	function automatic stim_row_t known_row(input op_t op, input longint unsigned ps, us, tg, wb,
			input status_t st, input longint unsigned pos);
		stim_row_t row;
		row = item_row(op, ps, us, tg, wb);
		row.typed = 1'b1;
		row.known.status = st;
		row.known.position_now = FIELD_W'(pos);
		return row;
	endfunction

	// Chunk header: mostly one that fits, with its sizes chosen per mode
	function automatic item_t gen_add();
		longint unsigned room, psz, usz;
		int r;
		room = (t_next_hdr < r_file_size && r_file_size - t_next_hdr >= HDR_BYTES) ?
			r_file_size - t_next_hdr - HDR_BYTES : 0;
		r = $urandom_range(0, 19);
		if (room == 0 || r == 0) begin
			psz = edge48();
			usz = edge48();
		end else begin
			psz = 1 + rnd_upto((r < 15 && room > 4096) ? 4095 : room - 1);
			if (r == 4)
				psz = room + 1;
			if (r == 5)
				psz = room;
			if (r_mode == MODE_UNCOMP && r != 1)
				usz = (r % 2 == 1 && psz > HDR_BYTES) ? psz - HDR_BYTES : psz;
			else
				usz = (r > 17) ? 1 + rnd_upto(POS_MASK - 1) : $urandom_range(1, 4000);
			// position space filled exactly, or one past it
			if (r == 2 && t_plain_end < POS_MASK)
				usz = POS_MASK - t_plain_end;
			if (r == 3)
				usz = (POS_MASK - t_plain_end + 1) & POS_MASK;
		end
		return mk_item(OP_ADD, psz, usz, rnd48(), rnd48());
	endfunction

	// Seek, mostly to chunk starts, chunk ends and points inside chunks
	function automatic item_t gen_seek();
		longint unsigned tgt;
		int r, j;
		r = $urandom_range(0, 9);
		case (r)
			0: tgt = 0;
			1: tgt = t_plain_end;
			2: tgt = (t_plain_end + 1) & POS_MASK;
			3: tgt = rnd48();
			default: begin
				if (t_count == 0)
					tgt = edge48();
				else begin
					j = (r == 4) ? t_count - 1 : $urandom_range(0, t_count - 1);
					tgt = t_pl_off[j] + ((r == 5) ? t_pl_size[j] - 1 : rnd_upto(t_pl_size[j] - 1));
				end
			end
		endcase
		return mk_item(OP_SEEK, rnd48(), rnd48(), tgt & POS_MASK, rnd48());
	endfunction

	// Read, mostly within what remains after the position
	function automatic item_t gen_read();
		longint unsigned rem, want;
		int r;
		rem = t_plain_end - t_pos;
		r = $urandom_range(0, 9);
		case (r)
			0: want = 0;
			1: want = rem;
			2: want = (rem + 1) & POS_MASK;
			3: want = rnd48();
			default: begin
				if (rem == 0)
					want = edge48();
				else
					want = 1 + rnd_upto((r < 7 && rem > 300) ? 299 : rem - 1);
			end
		endcase
		return mk_item(OP_READ, rnd48(), rnd48(), rnd48(), want);
	endfunction

	// Offer one item, with random gaps before it, and note its span once taken
	task automatic send_item(input item_t it, input bit typed = 1'b0, input result_t known = '0);
		result_t owed;
		cfg_valid <= 1'b0;
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		owed = step_chunk_map(it);
		owe_span(typed ? known : owed);
	endtask

	// Stop offering and wait until every owed span has come back
	task automatic settle();
		start <= 1'b0;
		while (owed_spans.size() != 0)
			@(posedge clk);
	endtask

	// valid stays high so back-to-back writes need no gap; send_item lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= FIELD_W'(val);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_FILE_SIZE: r_file_size = val & POS_MASK;
			CFG_FIRST_OFFSET: r_first_off = val & POS_MASK;
			CFG_MODE: r_mode = val[1:0];
			default: ;
		endcase
	endtask

	// Sessions: new settings, usually a clear, a run of headers, then mixed traffic and noise
	task automatic run_random(input int n_items, input int pct);
		int sent, n_add, len;
		longint unsigned fsz, first;
		int mode;
		idle_pct = pct;
		sent = 0;
		while (sent < n_items) begin
			settle();
			case ($urandom_range(0, 9))
				0: fsz = 0;
				1, 2: fsz = POS_MASK;
				3: fsz = $urandom_range(16, 4000);
				default: fsz = rnd48();
			endcase
			case ($urandom_range(0, 7))
				0: first = 0;
				1: first = POS_MASK;
				2: first = (fsz >= HDR_BYTES) ? fsz - HDR_BYTES : 0;
				3: first = (fsz >= HDR_BYTES - 1) ? fsz - HDR_BYTES + 1 : 0;
				default: first = rnd_upto(fsz / 2);
			endcase
			mode = $urandom_range(0, 5);
			write_reg(CFG_FILE_SIZE, fsz);
			write_reg(CFG_FIRST_OFFSET, first);
			write_reg(CFG_MODE, (mode > 3) ? MODE_UNCOMP : mode);
			if ($urandom_range(0, 9) != 0) begin
				send_item(mk_item(OP_CLEAR, rnd48(), rnd48(), rnd48(), rnd48()));
				sent++;
			end
			n_add = $urandom_range(1, 24);
			repeat (n_add) begin
				send_item(gen_add());
				sent++;
			end
			len = $urandom_range(10, 40);
			repeat (len) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8: send_item(gen_read());
					9, 10, 11, 12: send_item(gen_seek());
					13, 14: send_item(gen_add());
					15: send_item(mk_item(OP_CLEAR, rnd48(), rnd48(), rnd48(), rnd48()));
					default: send_item(mk_item(op_t'($urandom_range(0, 3)), edge48(), edge48(),
						edge48(), edge48()));
				endcase
				sent++;
			end
		end
	endtask

	function automatic string show_span(input result_t r);
		return $sformatf("st=%0d chunk=%0d poff=%h psize=%h inner=%h bytes=%h reload=%0d pos=%h",
			r.status, r.span_chunk, r.span_packed_offset, r.span_packed_size,
			r.span_inner_offset, r.span_bytes, r.span_reload, r.position_now);
	endfunction

	function automatic string span_diff(input result_t e, input result_t a);
		string s = "";
		if (a.status !== e.status) s = {s, " status"};
		if (a.span_chunk !== e.span_chunk) s = {s, " span_chunk"};
		if (a.span_packed_offset !== e.span_packed_offset) s = {s, " span_packed_offset"};
		if (a.span_packed_size !== e.span_packed_size) s = {s, " span_packed_size"};
		if (a.span_inner_offset !== e.span_inner_offset) s = {s, " span_inner_offset"};
		if (a.span_bytes !== e.span_bytes) s = {s, " span_bytes"};
		if (a.span_reload !== e.span_reload) s = {s, " span_reload"};
		if (a.position_now !== e.position_now) s = {s, " position_now"};
		return s;
	endfunction

	// Each strobed span against the oldest one owed
	always @(posedge clk) begin : span_check
		result_t owed;
		string diff;
		if (arst_n && done) begin
			if (owed_spans.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_MAX)
					$display("unexpected span at %0t: %s", $realtime, show_span(result));
			end else begin
				owed = owed_spans.pop_front();
				diff = span_diff(owed, result);
				if (diff != "") begin
					mismatches++;
					if (mismatches <= SHOW_MAX) begin
						$display("span mismatch at %0t:%s", $realtime, diff);
						$display("  expected %s", show_span(owed));
						$display("  actual   %s", show_span(result));
					end
				end
			end
		end
	end

	// Ends the run if nothing moves on any channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int sz;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: empty table, zero-length file
		add_row(known_row(OP_READ, 0, 0, 0, POS_MASK, STAT_NONE, 0));
		add_row(known_row(OP_SEEK, 0, 0, POS_MASK, 0, STAT_RANGE, 0));
		add_row(known_row(OP_SEEK, 0, 0, 0, 0, STAT_OK, 0));
		add_row(known_row(OP_ADD, 1, 1, 0, 0, STAT_TRUNCATED, 0));
		add_row(known_row(OP_CLEAR, POS_MASK, POS_MASK, POS_MASK, POS_MASK, STAT_OK, 0));
		// first header with fewer than a header's bytes left
		add_row(reg_row(CFG_FILE_SIZE, 1000));
		add_row(reg_row(CFG_FIRST_OFFSET, 990));
		add_row(known_row(OP_CLEAR, 0, 0, 0, 0, STAT_OK, 0));
		add_row(known_row(OP_ADD, 1, 1, 0, 0, STAT_TRUNCATED, 0));
		// header errors, then three chunks: raw, raw plus header, bad sizes
		add_row(reg_row(CFG_FIRST_OFFSET, 0));
		add_row(known_row(OP_CLEAR, 0, 0, 0, 0, STAT_OK, 0));
		add_row(known_row(OP_ADD, 0, 5, 0, 0, STAT_EMPTY, 0));
		add_row(known_row(OP_ADD, 5, 0, 0, 0, STAT_EMPTY, 0));
		add_row(known_row(OP_ADD, 985, 985, 0, 0, STAT_PAST_END, 0));
		add_row(known_row(OP_ADD, POS_MASK, 1, 0, 0, STAT_PAST_END, 0));
		add_row(item_row(OP_ADD, 100, 100, 0, 0));
		add_row(item_row(OP_ADD, 116, 100, 0, 0));
		add_row(item_row(OP_ADD, 50, 200, 0, 0));
		add_row(known_row(OP_ADD, 10, POS_MASK, 0, 0, STAT_OVERFLOW, 0));
		// reads: zero length, across a boundary, reuse, size mismatch, out of range
		add_row(known_row(OP_READ, 0, 0, 0, 0, STAT_OK, 0));
		add_row(item_row(OP_READ, 0, 0, 0, 150));
		add_row(item_row(OP_READ, 0, 0, 0, 50));
		add_row(item_row(OP_READ, 0, 0, 0, 50));
		add_row(item_row(OP_READ, 0, 0, 0, 10));
		add_row(known_row(OP_SEEK, 0, 0, 401, 0, STAT_RANGE, 200));
		add_row(known_row(OP_READ, 0, 0, 0, 201, STAT_RANGE, 200));
		// compressed mode skips the size check
		add_row(reg_row(CFG_MODE, 1));
		add_row(item_row(OP_READ, 0, 0, 0, 200));
		add_row(known_row(OP_SEEK, 0, 0, 400, 0, STAT_OK, 400));
		add_row(known_row(OP_READ, 0, 0, 0, 1, STAT_RANGE, 400));
		// top of every register
		add_row(reg_row(CFG_MODE, 3));
		add_row(reg_row(CFG_FILE_SIZE, POS_MASK));
		add_row(reg_row(CFG_FIRST_OFFSET, POS_MASK));
		add_row(known_row(OP_CLEAR, 0, 0, 0, 0, STAT_OK, 0));
		add_row(known_row(OP_ADD, 1, 1, 0, 0, STAT_TRUNCATED, 0));
		add_row(known_row(OP_READ, 0, 0, 0, POS_MASK, STAT_NONE, 0));

		idle_pct = 9;
		foreach (rows[i]) begin
			if (rows[i].kind == ROW_REG) begin
				settle();
				write_reg(rows[i].reg_idx, rows[i].reg_val);
			end else begin
				send_item(rows[i].cmd, rows[i].typed, rows[i].known);
			end
		end

		run_random(ITEMS_FEW_GAPS, 9);
		run_random(ITEMS_SLOW_GAPS, 84);
		run_random(ITEMS_NO_GAPS, 0);

		// build a long table, then search it
		settle();
		write_reg(CFG_FILE_SIZE, POS_MASK);
		write_reg(CFG_FIRST_OFFSET, rnd_upto(4095));
		write_reg(CFG_MODE, MODE_UNCOMP);
		send_item(mk_item(OP_CLEAR, 0, 0, 0, 0));
		repeat (LONG_CHUNKS) begin
			sz = $urandom_range(1, 64);
			send_item(mk_item(OP_ADD, sz, sz, 0, 0));
		end
		repeat (LONG_MIXED) begin
			if ($urandom_range(0, 1) == 0)
				send_item(gen_seek());
			else
				send_item(gen_read());
		end

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && owed_spans.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
